// ===== hw/rtl/csba_pkg.sv =====
`timescale 1ns / 1ps

package csba_pkg;

  // Largest rank the address unit accepts by default.
  localparam int unsigned CSBA_MAX_AXES = 8;

  // Field widths of the transactions and registers.
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned ADDR_W   = 63;
  localparam int unsigned RANK_W   = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PADDR_W  = 4;

  // Register map, one 64-bit register every eight bytes.
  localparam logic REG_BASE_OFFSET = 1'b0;
  localparam logic REG_RANK        = 1'b1;

  // Result status codes; ST_OK also means "no address error recorded".
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BIG     = 3'd1,
    ST_RANK    = 3'd2,
    ST_COVER   = 3'd3,
    ST_SMIN    = 3'd4,
    ST_SPAN    = 3'd5,
    ST_SUM     = 3'd6,
    ST_PRECEDE = 3'd7
  } status_t;

endpackage

// ===== hw/rtl/csba_if.sv =====
`timescale 1ns / 1ps

// One axis of a coordinate.
interface csba_in_if import csba_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [WORD_W-1:0]        coord;
  logic [WORD_W-1:0]        axis_origin;
  logic signed [WORD_W-1:0] axis_stride;
  logic [WORD_W-1:0]        cover_start;
  logic [WORD_W-1:0]        cover_extent;
  logic                     last_axis;

  modport source (
    output valid, coord, axis_origin, axis_stride, cover_start, cover_extent, last_axis,
    input  ready
  );
  modport sink (
    input  valid, coord, axis_origin, axis_stride, cover_start, cover_extent, last_axis,
    output ready
  );
endinterface

// One computed address with its status.
interface csba_out_if import csba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   byte_addr;
  logic [STATUS_W-1:0] status;

  modport source (output valid, byte_addr, status, input ready);
  modport sink (input valid, byte_addr, status, output ready);
endinterface

// ===== hw/rtl/checked_strided_byte_address.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Transaction contents
// ----------+-----------+------------------------------------------------------------
// in_ch     | in        | coord, axis_origin, axis_stride, cover_start, cover_extent,
//           |           | last_axis (one axis per transaction)
// out_ch    | out       | byte_addr, status (one per coordinate, on the last axis)
// APB       | in        | base_offset at 0x0, rank at 0x8 (64-bit data)
//
// Each axis passes through the accept state, the multiply steps on the shared 32x32
// multiplier (four partial products, registered and accumulated one behind),
// and the span and coverage checks. The last axis then forms the result once
// the output register is free, holding for as long as that register stays stalled.
// Reset clears the sequencer, the sums and the output valid; base_offset
// resets to 0 and rank to 1. A result waiting in the output register does not
// block work on the next coordinate's axes.
module checked_strided_byte_address import csba_pkg::*; #(
  parameter int unsigned MAX_AXES = CSBA_MAX_AXES
) (
  input  logic               clk,
  input  logic               rst_n,
  csba_in_if.sink            in_ch,
  csba_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output logic [WORD_W-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned CNT_W = $clog2(MAX_AXES + 2);
  localparam int unsigned CMP_W = CNT_W + RANK_W;
  localparam int unsigned HALF_W = WORD_W / 2;
  localparam int unsigned ACC_W = 2 * WORD_W;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_AXES + 1);
  localparam logic [2:0] LAST_STEP = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ACC  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  // Configuration registers.
  logic [WORD_W-1:0] base_r, base_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;

  // Sequencer and coordinate state.
  state_t            state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [WORD_W-1:0] plus_r, plus_nxt;
  logic [ADDR_W-1:0] minus_r, minus_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              cov_r, cov_nxt;
  status_t           err_r, err_nxt;

  // Per-axis operands.
  logic [WORD_W-1:0] dist_r, dist_nxt;
  logic [ADDR_W-1:0] mag_r, mag_nxt;
  logic              tminus_r, tminus_nxt;
  logic              skip_r, skip_nxt;
  logic              smin_r, smin_nxt;
  logic              last_r, last_nxt;
  logic [WORD_W:0]   cdiff_r, cdiff_nxt;
  logic [WORD_W-1:0] ce_r, ce_nxt;

  // Shared multiplier and product accumulator.
  logic [WORD_W-1:0] pp_r, pp_nxt;
  logic [1:0]        sh_r, sh_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  status_t           out_status_r, out_status_nxt;

  logic              in_fire;
  logic              cfg_wr;
  logic [WORD_W-1:0] mag_full;
  logic              neg_stride;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [1:0]        mul_sh;
  logic [ACC_W-1:0]  pp_shifted;
  logic [ADDR_W-1:0] span;
  logic              span_ovf;
  logic [WORD_W:0]   psum;
  logic [WORD_W-1:0] msum;
  logic              rank_bad;
  logic              out_free;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.byte_addr = out_addr_r;
  assign out_ch.status    = out_status_r;

  // Register reads; the write port never waits.
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_RANK) ? {{(WORD_W-RANK_W){1'b0}}, rank_r} : base_r;

  // Stride magnitude and direction of the incoming axis.
  assign neg_stride = in_ch.axis_stride[WORD_W-1];
  assign mag_full   = neg_stride ? (WORD_W'(0) - in_ch.axis_stride) : in_ch.axis_stride;

  // Operand halves for each partial product of dist * mag.
  always_comb begin
    case (step_r)
      3'd0: begin
        mul_a = dist_r[HALF_W-1:0];
        mul_b = mag_r[HALF_W-1:0];
        mul_sh = 2'd0;
      end
      3'd1: begin
        mul_a = dist_r[HALF_W-1:0];
        mul_b = {1'b0, mag_r[ADDR_W-1:HALF_W]};
        mul_sh = 2'd1;
      end
      3'd2: begin
        mul_a = dist_r[WORD_W-1:HALF_W];
        mul_b = mag_r[HALF_W-1:0];
        mul_sh = 2'd1;
      end
      3'd3: begin
        mul_a = dist_r[WORD_W-1:HALF_W];
        mul_b = {1'b0, mag_r[ADDR_W-1:HALF_W]};
        mul_sh = 2'd2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
        mul_sh = 2'd0;
      end
    endcase
  end

  // Align the registered partial product to its weight.
  always_comb begin
    case (sh_r)
      2'd0:    pp_shifted = {{WORD_W{1'b0}}, pp_r};
      2'd1:    pp_shifted = {{HALF_W{1'b0}}, pp_r, {HALF_W{1'b0}}};
      2'd2:    pp_shifted = {pp_r, {WORD_W{1'b0}}};
      default: pp_shifted = '0;
    endcase
  end

  // The span is valid only when the full product fits in 63 bits.
  assign span     = acc_r[ADDR_W-1:0];
  assign span_ovf = |acc_r[ACC_W-1:ADDR_W];
  assign psum     = {1'b0, plus_r} + {2'b00, span};
  assign msum     = {1'b0, minus_r} + {1'b0, span};

  // Rank check for the finished coordinate.
  assign rank_bad = (rank_r == '0) || (CMP_W'(rank_r) > CMP_W'(MAX_AXES)) ||
                    (CMP_W'(cnt_r) != CMP_W'(rank_r));

  // Next-state logic of the sequencer and datapath.
  always_comb begin
    base_nxt       = base_r;
    rank_nxt       = rank_r;
    state_nxt      = state_r;
    step_nxt       = step_r;
    plus_nxt       = plus_r;
    minus_nxt      = minus_r;
    cnt_nxt        = cnt_r;
    cov_nxt        = cov_r;
    err_nxt        = err_r;
    dist_nxt       = dist_r;
    mag_nxt        = mag_r;
    tminus_nxt     = tminus_r;
    skip_nxt       = skip_r;
    smin_nxt       = smin_r;
    last_nxt       = last_r;
    cdiff_nxt      = cdiff_r;
    ce_nxt         = ce_r;
    pp_nxt         = pp_r;
    sh_nxt         = sh_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;

    // Configuration writes.
    if (cfg_wr) begin
      if (paddr[3] == REG_BASE_OFFSET) begin
        base_nxt = pwdata;
      end else begin
        rank_nxt = pwdata[RANK_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // The first axis of a coordinate starts from the base offset.
          if (cnt_r == '0) begin
            plus_nxt  = base_r;
            minus_nxt = '0;
            err_nxt   = base_r[WORD_W-1] ? ST_BIG : ST_OK;
          end
          if (cnt_r != CNT_SAT) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          dist_nxt   = (in_ch.coord >= in_ch.axis_origin) ?
                       (in_ch.coord - in_ch.axis_origin) : (in_ch.axis_origin - in_ch.coord);
          mag_nxt    = mag_full[ADDR_W-1:0];
          tminus_nxt = (in_ch.coord < in_ch.axis_origin) != neg_stride;
          skip_nxt   = (in_ch.coord == in_ch.axis_origin) || (in_ch.axis_stride == '0);
          smin_nxt   = neg_stride && (in_ch.axis_stride[WORD_W-2:0] == '0);
          last_nxt   = in_ch.last_axis;
          cdiff_nxt  = {1'b0, in_ch.coord} - {1'b0, in_ch.cover_start};
          ce_nxt     = in_ch.cover_extent;
          acc_nxt    = '0;
          step_nxt   = '0;
          state_nxt  = S_MUL;
        end
      end
      S_MUL: begin
        // One partial product per cycle, registered and accumulated in the next cycle.
        if (step_r != LAST_STEP) begin
          pp_nxt = WORD_W'(mul_a) * WORD_W'(mul_b);
          sh_nxt = mul_sh;
        end
        if (step_r != '0) begin
          acc_nxt = acc_r + pp_shifted;
        end
        if (step_r == LAST_STEP) begin
          state_nxt = S_ACC;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      S_ACC: begin
        // Coverage window check.
        if (cdiff_r[WORD_W] || (cdiff_r[WORD_W-1:0] >= ce_r)) begin
          cov_nxt = 1'b1;
        end
        // Add the span unless an earlier error froze the sums or the axis is skipped.
        if ((err_r == ST_OK) && !skip_r) begin
          if (smin_r) begin
            err_nxt = ST_SMIN;
          end else if (span_ovf) begin
            err_nxt = ST_SPAN;
          end else if (tminus_r) begin
            if (msum[WORD_W-1]) begin
              err_nxt = ST_SUM;
            end else begin
              minus_nxt = msum[ADDR_W-1:0];
            end
          end else begin
            if (|psum[WORD_W:ADDR_W]) begin
              err_nxt = ST_SUM;
            end else begin
              plus_nxt = psum[WORD_W-1:0];
            end
          end
        end
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // Form the result once the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          if (rank_bad) begin
            out_status_nxt = ST_RANK;
          end else if (cov_r) begin
            out_status_nxt = ST_COVER;
          end else if (err_r != ST_OK) begin
            out_status_nxt = err_r;
          end else if ({1'b0, minus_r} > plus_r) begin
            out_status_nxt = ST_PRECEDE;
          end else begin
            out_status_nxt = ST_OK;
            out_addr_nxt   = plus_r[ADDR_W-1:0] - minus_r;
          end
          plus_nxt  = '0;
          minus_nxt = '0;
          cnt_nxt   = '0;
          cov_nxt   = 1'b0;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      rank_r      <= RANK_W'(1);
      state_r     <= S_IDLE;
      step_r      <= '0;
      plus_r      <= '0;
      minus_r     <= '0;
      cnt_r       <= '0;
      cov_r       <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      rank_r      <= rank_nxt;
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      plus_r      <= plus_nxt;
      minus_r     <= minus_nxt;
      cnt_r       <= cnt_nxt;
      cov_r       <= cov_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    dist_r       <= dist_nxt;
    mag_r        <= mag_nxt;
    tminus_r     <= tminus_nxt;
    skip_r       <= skip_nxt;
    smin_r       <= smin_nxt;
    last_r       <= last_nxt;
    cdiff_r      <= cdiff_nxt;
    ce_r         <= ce_nxt;
    pp_r         <= pp_nxt;
    sh_r         <= sh_nxt;
    acc_r        <= acc_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== hw/rtl/csba_checker.sv =====
`timescale 1ns / 1ps

module csba_checker import csba_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last_axis,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ADDR_W-1:0]   out_byte_addr,
  input logic [STATUS_W-1:0] out_status
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_addr) && $stable(out_status))
    else $error("stalled result changed");

  // A failed address always reads as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_byte_addr == '0)
    else $error("nonzero address with error status");

  // The multiplier sequence keeps the input closed after each transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input reopened during axis processing");

  // A non-last axis never produces a result within its processing window.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_axis && !out_valid |=> !out_valid)
    else $error("result without a last axis");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind checked_strided_byte_address csba_checker u_csba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_last_axis  (in_ch.last_axis),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte_addr (out_ch.byte_addr),
  .out_status    (out_ch.status)
);

// ===== sim/checked_strided_byte_address_tb.sv =====
`timescale 1ns / 1ps

module checked_strided_byte_address_tb;
  import csba_pkg::*;

  localparam int unsigned MAX_AXES = CSBA_MAX_AXES;
  localparam logic [WORD_W-1:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] I64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
  localparam logic [PADDR_W-1:0] ADDR_BASE_OFFSET = PADDR_W'({REG_BASE_OFFSET, 3'b000});
  localparam logic [PADDR_W-1:0] ADDR_RANK = PADDR_W'({REG_RANK, 3'b000});
  localparam int unsigned RANDOM_AXES = 800;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // One axis transaction as queued for the driver.
  typedef struct packed {
    logic [WORD_W-1:0] coord;
    logic [WORD_W-1:0] origin;
    logic [WORD_W-1:0] stride;
    logic [WORD_W-1:0] cstart;
    logic [WORD_W-1:0] cext;
    logic              last;
  } axis_item_t;

  // One predicted address result.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } addr_result_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [WORD_W-1:0]  pwdata;
  logic [WORD_W-1:0]  prdata;
  logic               pready;

  csba_in_if  in_ch ();
  csba_out_if out_ch ();

  checked_strided_byte_address #(
    .MAX_AXES(MAX_AXES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the registers and of the address accumulator.
  logic [WORD_W-1:0] cfg_base;
  logic [RANK_W-1:0] cfg_rank;
  logic [WORD_W-1:0] plus_acc;
  logic [WORD_W-1:0] minus_acc;
  int unsigned       axes_seen;
  logic              cover_missed;
  status_t           addr_err;

  axis_item_t   axis_queue[$];
  addr_result_t expected_addrs[$];

  axis_item_t  cur_axis;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned n_axes_sent;
  int unsigned n_addrs_checked;
  int unsigned n_errors;
  int unsigned n_settings;
  int unsigned status_seen[8];
  logic        steady;

  always #4 clk = ~clk;

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Boundary values mixed with random words.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 64'd1;
      2: return ALL_ONES;
      3: return I64_MAX;
      4: return I64_MIN;
      5: return 64'($urandom_range(0, 255));
      default: return rand64();
    endcase
  endfunction

  // Idle length: mostly none, some short, a few long; none in steady phases.
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (steady || p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Accumulate one axis into the address and, on the last axis, queue the result.
  task automatic predict_axis(input axis_item_t a);
    logic [WORD_W-1:0]   mag;
    logic [WORD_W-1:0]   axis_dist;
    logic [WORD_W-1:0]   span;
    logic [2*WORD_W-1:0] prod;
    logic                neg;
    logic                toward_minus;
    addr_result_t        r;
    if (axes_seen == 0) begin
      plus_acc = cfg_base;
      minus_acc = '0;
      if (cfg_base > I64_MAX) addr_err = ST_BIG;
    end
    if (axes_seen < MAX_AXES + 1) axes_seen++;
    if (a.coord < a.cstart || a.coord - a.cstart >= a.cext) cover_missed = 1'b1;

    // A recorded error freezes the sums; a zero stride or zero distance adds nothing.
    if (addr_err == ST_OK && a.coord != a.origin && a.stride != '0) begin
      if (a.stride == I64_MIN) begin
        addr_err = ST_SMIN;
      end else begin
        neg = a.stride[WORD_W-1];
        mag = neg ? -a.stride : a.stride;
        axis_dist = (a.coord >= a.origin) ? a.coord - a.origin : a.origin - a.coord;
        prod = {{WORD_W{1'b0}}, axis_dist} * {{WORD_W{1'b0}}, mag};
        if (prod > {{WORD_W{1'b0}}, I64_MAX}) begin
          addr_err = ST_SPAN;
        end else begin
          span = prod[WORD_W-1:0];
          toward_minus = (a.coord < a.origin) != neg;
          if (toward_minus) begin
            if (span > I64_MAX - minus_acc) addr_err = ST_SUM;
            else minus_acc = minus_acc + span;
          end else begin
            if (span > I64_MAX - plus_acc) addr_err = ST_SUM;
            else plus_acc = plus_acc + span;
          end
        end
      end
    end

    if (a.last) begin
      r.addr = '0;
      if (cfg_rank == 0 || cfg_rank > MAX_AXES || axes_seen != cfg_rank) begin
        r.status = ST_RANK;
      end else if (cover_missed) begin
        r.status = ST_COVER;
      end else if (addr_err != ST_OK) begin
        r.status = addr_err;
      end else if (minus_acc > plus_acc) begin
        r.status = ST_PRECEDE;
      end else begin
        r.status = ST_OK;
        r.addr = ADDR_W'(plus_acc - minus_acc);
      end
      expected_addrs = {expected_addrs, r};
      plus_acc = '0;
      minus_acc = '0;
      axes_seen = 0;
      cover_missed = 1'b0;
      addr_err = ST_OK;
    end
  endtask

  // Driver: presents queued axes, holds them until accepted, then idles at random.
  always @(posedge clk) begin : driver
    axis_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_axis(cur_axis);
        n_axes_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the current transaction.
      end else if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (axis_queue.size() != 0) begin
        nxt = axis_queue.pop_front();
        cur_axis <= nxt;
        in_ch.coord <= nxt.coord;
        in_ch.axis_origin <= nxt.origin;
        in_ch.axis_stride <= nxt.stride;
        in_ch.cover_start <= nxt.cstart;
        in_ch.cover_extent <= nxt.cext;
        in_ch.last_axis <= nxt.last;
        in_ch.valid <= 1'b1;
        send_gap <= idle_len();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each address transaction with the oldest prediction.
  always @(posedge clk) begin : monitor
    addr_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_addrs.size() == 0) begin
          $display("%0t: unexpected result, byte_addr %h status %0d", $time,
                   out_ch.byte_addr, out_ch.status);
          n_errors++;
        end else begin
          want = expected_addrs.pop_front();
          if (out_ch.byte_addr !== want.addr) begin
            $display("%0t: byte_addr mismatch, expected %h, actual %h", $time,
                     want.addr, out_ch.byte_addr);
            n_errors++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_ch.status);
            n_errors++;
          end
          n_addrs_checked++;
          status_seen[want.status]++;
        end
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left <= idle_len();
      end
    end
  end

  // Watchdog: ends the run when no transaction or register write happens for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write: setup phase, then access phase until pready.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_RANK) cfg_rank = data[RANK_W-1:0];
    else cfg_base = data;
  endtask

  task automatic set_config(input logic [WORD_W-1:0] base, input logic [RANK_W-1:0] rank_val);
    write_reg(ADDR_BASE_OFFSET, base);
    write_reg(ADDR_RANK, WORD_W'(rank_val));
    n_settings++;
    @(negedge clk);
  endtask

  task automatic add_axis(input logic [WORD_W-1:0] c, input logic [WORD_W-1:0] o,
                          input logic [WORD_W-1:0] s, input logic [WORD_W-1:0] cs,
                          input logic [WORD_W-1:0] ce, input logic last);
    axis_item_t a;
    a = '{coord: c, origin: o, stride: s, cstart: cs, cext: ce, last: last};
    axis_queue = {axis_queue, a};
  endtask

  // Let every queued axis go out and every result come back, then let the block settle.
  task automatic drain();
    @(negedge clk);
    while (axis_queue.size() != 0 || in_ch.valid || expected_addrs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One coordinate of n axes. Flavor 0 is well formed, 1 misses coverage on one axis,
  // 2 replaces fields with boundary or random words.
  task automatic gen_coord(input int unsigned n, input int unsigned flavor);
    logic [WORD_W-1:0] c, o, d, s, cs, ce, off;
    int unsigned       miss_at;
    miss_at = $urandom_range(0, n - 1);
    for (int unsigned i = 0; i < n; i++) begin
      o = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 1000));
      case ($urandom_range(0, 9))
        0, 1: d = '0;
        2: d = rand64() >> $urandom_range(1, 63);
        default: d = 64'($urandom_range(1, 5000));
      endcase
      if ($urandom_range(0, 1) && o >= d) c = o - d;
      else if (o <= ~d) c = o + d;
      else c = o - d;
      s = rand64() >> $urandom_range(22, 63);
      if ($urandom_range(0, 1)) s = -s;
      if ($urandom_range(0, 11) == 0) s = '0;
      off = 64'($urandom_range(0, 50));
      if (off > c) off = c;
      cs = c - off;
      ce = ($urandom_range(0, 7) == 0) ? ALL_ONES : off + 1 + 64'($urandom_range(0, 50));
      if (flavor == 1 && i == miss_at) begin
        if ($urandom_range(0, 1) && c != ALL_ONES) cs = c + 1;
        else ce = off;
      end
      if (flavor == 2) begin
        case ($urandom_range(0, 5))
          0: c = pick_word();
          1: o = pick_word();
          2: s = pick_word();
          3: cs = pick_word();
          4: ce = pick_word();
          default: begin
            c = rand64();
            o = rand64();
            s = rand64();
          end
        endcase
      end
      add_axis(c, o, s, cs, ce, i == n - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned       ph;
    int unsigned       queued;
    int unsigned       target;
    int unsigned       n;
    int unsigned       p;
    logic [RANK_W-1:0] r;
    logic [WORD_W-1:0] b;

    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.coord = '0;
    in_ch.axis_origin = '0;
    in_ch.axis_stride = '0;
    in_ch.cover_start = '0;
    in_ch.cover_extent = '0;
    in_ch.last_axis = 1'b0;
    out_ch.ready = 1'b0;
    cur_axis = '0;
    cfg_base = '0;
    cfg_rank = RANK_W'(1);
    plus_acc = '0;
    minus_acc = '0;
    axes_seen = 0;
    cover_missed = 1'b0;
    addr_err = ST_OK;
    send_gap = 0;
    stall_left = 0;
    idle_cycles = 0;
    n_axes_sent = 0;
    n_addrs_checked = 0;
    n_errors = 0;
    n_settings = 0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    steady = 1'b0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Single axis: zero and all-ones fields, skipped axes, the stride and span errors,
    // an address below zero, each coverage miss, and too many axes for the rank.
    set_config('0, RANK_W'(1));
    add_axis('0, '0, '0, '0, 64'd1, 1'b1);
    add_axis(ALL_ONES, ALL_ONES, I64_MAX, ALL_ONES, 64'd1, 1'b1);
    add_axis(64'd100, '0, '0, '0, ALL_ONES, 1'b1);
    add_axis(64'd1, '0, I64_MIN, '0, 64'd2, 1'b1);
    add_axis(64'd2, '0, I64_MAX, '0, 64'd3, 1'b1);
    add_axis(64'd5, '0, -64'd1, '0, 64'd6, 1'b1);
    add_axis('0, 64'd5, -64'd3, '0, 64'd1, 1'b1);
    add_axis(64'd3, '0, 64'd1, 64'd4, 64'd10, 1'b1);
    add_axis(64'd14, '0, 64'd1, 64'd4, 64'd10, 1'b1);
    add_axis(64'd4, '0, 64'd1, 64'd4, '0, 1'b1);
    add_axis(64'd9, '0, I64_MIN, 64'd10, 64'd1, 1'b1);
    add_axis(64'd1, '0, 64'd1, '0, 64'd2, 1'b0);
    add_axis(64'd1, '0, 64'd1, '0, 64'd2, 1'b1);
    drain();

    // Base at the top of the signed range: sum overflow, a negative span that fits,
    // and an error that later axes must not overwrite.
    set_config(I64_MAX, RANK_W'(2));
    add_axis(64'd1, '0, 64'd1, '0, 64'd2, 1'b0);
    add_axis('0, '0, 64'd5, '0, 64'd1, 1'b1);
    add_axis(64'd1, '0, -64'd1, '0, 64'd2, 1'b0);
    add_axis('0, '0, 64'd5, '0, 64'd1, 1'b1);
    add_axis(64'd1, '0, I64_MIN, '0, 64'd2, 1'b0);
    add_axis(64'd1, '0, 64'd1, '0, 64'd2, 1'b1);
    drain();

    // Base offset too big for a signed address.
    set_config(I64_MIN, RANK_W'(3));
    add_axis('0, '0, 64'd7, '0, 64'd1, 1'b0);
    add_axis(64'd3, 64'd3, 64'd7, '0, 64'd4, 1'b0);
    add_axis(64'd8, '0, '0, '0, 64'd9, 1'b1);
    drain();

    // Rank of zero never matches.
    set_config(ALL_ONES, '0);
    add_axis('0, '0, '0, '0, 64'd1, 1'b1);
    drain();

    // Random phases, each with its own register setting; the sender waits for all
    // results at the end of every phase.
    ph = 0;
    queued = 0;
    while (queued < RANDOM_AXES) begin
      if (ph == 0) begin
        r = RANK_W'(MAX_AXES);
      end else if (ph == 1) begin
        r = '1;
      end else begin
        p = $urandom_range(0, 19);
        if (p == 0) r = '0;
        else if (p == 1) r = RANK_W'($urandom_range(MAX_AXES + 1, 15));
        else r = RANK_W'($urandom_range(1, MAX_AXES));
      end
      case ((ph == 1) ? 9 : $urandom_range(0, 9))
        0: b = '0;
        1: b = I64_MAX;
        2: b = rand64() | I64_MIN;
        3: b = rand64();
        9: b = ALL_ONES;
        default: b = rand64() >> $urandom_range(8, 63);
      endcase
      set_config(b, r);
      steady = (ph % 5 == 3);
      target = $urandom_range(20, 90);
      for (int unsigned k = 0; k < target; k += n) begin
        if (r >= 1 && r <= MAX_AXES && $urandom_range(0, 6) != 0) n = r;
        else n = $urandom_range(1, MAX_AXES + 2);
        p = $urandom_range(0, 9);
        gen_coord(n, (p < 7) ? 0 : (p == 7) ? 1 : 2);
        queued += n;
      end
      drain();
      steady = 1'b0;
      ph++;
    end

    $display("Sent %0d axis transactions under %0d register settings, checked %0d addresses.",
             n_axes_sent, n_settings, n_addrs_checked);
    $display({"Status mix: ok %0d, base %0d, rank %0d, coverage %0d, stride %0d, ",
              "span %0d, sum %0d, precedes %0d."},
             status_seen[ST_OK], status_seen[ST_BIG], status_seen[ST_RANK],
             status_seen[ST_COVER], status_seen[ST_SMIN], status_seen[ST_SPAN],
             status_seen[ST_SUM], status_seen[ST_PRECEDE]);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
